@@ hdl/wavp_pkg.sv @@
// Shared types, codes and constants of the WAV header parser.
`timescale 1ns / 1ps

package wavp_pkg;

	localparam int RATE_W  = 20;
	localparam int COUNT_W = 31;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_SIZE     = 32'd16;
	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] MONO         = 16'd1;
	localparam logic [15:0] BLOCK_ALIGN  = 16'd2;
	localparam logic [15:0] SAMPLE_BITS  = 16'd16;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [3:0] ERR_NOT_RIFF  = 4'd0;
	localparam logic [3:0] ERR_NOT_WAVE  = 4'd1;
	localparam logic [3:0] ERR_NO_FMT    = 4'd2;
	localparam logic [3:0] ERR_FMT_SIZE  = 4'd3;
	localparam logic [3:0] ERR_NOT_PCM   = 4'd4;
	localparam logic [3:0] ERR_CHANNELS  = 4'd5;
	localparam logic [3:0] ERR_RATE      = 4'd6;
	localparam logic [3:0] ERR_BITS      = 4'd7;
	localparam logic [3:0] ERR_ALIGN     = 4'd8;
	localparam logic [3:0] ERR_TRUNCATED = 4'd9;

	typedef enum logic [3:0] {
		PH_RIFF  = 4'd0,
		PH_FSIZE = 4'd1,
		PH_WAVE  = 4'd2,
		PH_FMT   = 4'd3,
		PH_FMTSZ = 4'd4,
		PH_CODE  = 4'd5,
		PH_CHAN  = 4'd6,
		PH_RATE  = 4'd7,
		PH_AVG   = 4'd8,
		PH_ALIGN = 4'd9,
		PH_BITS  = 4'd10,
		PH_TAG   = 4'd11,
		PH_SIZE  = 4'd12,
		PH_SKIP  = 4'd13,
		PH_SAMP  = 4'd14,
		PH_IDLE  = 4'd15
	} phase_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         kind;
		logic [15:0]        sample;
		logic [COUNT_W-1:0] sample_count;
		logic [3:0]         error_code;
		logic               last;
	} result_t;

endpackage

@@ hdl/wav_header_pcm_parser.sv @@
// Path: input register, combinational parser, then the result register.
// Throughput: one byte item per cycle while byte_stall is low; the parse stage
// and the result register advance together whenever the result register is empty
// or being taken. Reset (arst_n low) clears the parse state, the input valid flag
// and the result register at once and sets the expected sample rate to 44100.
`timescale 1ns / 1ps

module wav_header_pcm_parser import wavp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [RATE_W-1:0]  cfg_data,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         in_byte,
	input  logic               end_of_file,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         kind,
	output logic [15:0]        sample,
	output logic [COUNT_W-1:0] sample_count,
	output logic [3:0]         error_code,
	output logic               last
);

	logic [RATE_W-1:0] rate_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eof_s1;
	logic              advance;
	logic              step;
	result_t           res;
	result_t           res_s2;

	assign advance    = !res_s2.valid || !result_stall;
	assign byte_stall = valid_s1 && !advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_we) begin
			rate_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= in_byte;
			eof_s1  <= end_of_file;
		end
	end

	wavp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.in_byte      (byte_s1),
		.end_of_file  (eof_s1),
		.expected_rate(rate_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (advance) begin
			if (step && res.valid) begin
				res_s2 <= res;
			end else begin
				res_s2.valid <= 1'b0;
			end
		end
	end

	assign result_valid = res_s2.valid;
	assign kind         = res_s2.kind;
	assign sample       = res_s2.sample;
	assign sample_count = res_s2.sample_count;
	assign error_code   = res_s2.error_code;
	assign last         = res_s2.last;

endmodule

@@ hdl/wavp_parser.sv @@
// Byte-serial header state machine and sample assembler of the WAV parser.
`timescale 1ns / 1ps

module wavp_parser import wavp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        in_byte,
	input  logic              end_of_file,
	input  logic [RATE_W-1:0] expected_rate,
	output result_t           res
);

	phase_t      phase_q, phase_n;
	logic [1:0]  idx_q, idx_n;
	logic [31:0] asm_q, asm_n;
	logic [31:0] rem_q, rem_n;
	logic [7:0]  low_q, low_n;
	logic [15:0] half;
	logic        end4, end2;
	logic [31:0] rem_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			idx_q   <= '0;
			asm_q   <= '0;
			rem_q   <= '0;
			low_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			asm_q   <= asm_n;
			rem_q   <= rem_n;
			low_q   <= low_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		rem_n   = rem_q;
		low_n   = low_q;
		res     = '0;
		rem_dec = rem_q - 32'd1;

		// Bytes shift in from the top, so a finished field is little-endian.
		asm_n = (phase_q != PH_IDLE) ? {in_byte, asm_q[31:8]} : asm_q;
		half  = asm_n[31:16];

		end4 = (idx_q == 2'd3);
		end2 = idx_q[0] | idx_q[1];

		case (phase_q)
			PH_RIFF, PH_FSIZE, PH_WAVE, PH_FMT, PH_FMTSZ, PH_RATE, PH_AVG, PH_TAG,
			PH_SIZE: begin
				idx_n = end4 ? 2'd0 : idx_q + 2'd1;
			end
			PH_CODE, PH_CHAN, PH_ALIGN, PH_BITS: begin
				idx_n = end2 ? 2'd0 : idx_q + 2'd1;
			end
			default: begin
			end
		endcase

		case (phase_q)
			PH_RIFF: begin
				if (end4) begin
					if (asm_n != TAG_RIFF) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_NOT_RIFF, 1'b1};
					end else begin
						phase_n = PH_FSIZE;
					end
				end
			end
			PH_FSIZE: begin
				if (end4) phase_n = PH_WAVE;
			end
			PH_WAVE: begin
				if (end4) begin
					if (asm_n != TAG_WAVE) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_NOT_WAVE, 1'b1};
					end else begin
						phase_n = PH_FMT;
					end
				end
			end
			PH_FMT: begin
				if (end4) begin
					if (asm_n != TAG_FMT) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_NO_FMT, 1'b1};
					end else begin
						phase_n = PH_FMTSZ;
					end
				end
			end
			PH_FMTSZ: begin
				if (end4) begin
					if (asm_n != FMT_SIZE) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_FMT_SIZE, 1'b1};
					end else begin
						phase_n = PH_CODE;
					end
				end
			end
			PH_CODE: begin
				if (end2) begin
					if (half != FMT_PCM) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_NOT_PCM, 1'b1};
					end else begin
						phase_n = PH_CHAN;
					end
				end
			end
			PH_CHAN: begin
				if (end2) begin
					if (half != MONO) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_CHANNELS, 1'b1};
					end else begin
						phase_n = PH_RATE;
					end
				end
			end
			PH_RATE: begin
				if (end4) begin
					if (asm_n != 32'(expected_rate)) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_RATE, 1'b1};
					end else begin
						phase_n = PH_AVG;
					end
				end
			end
			PH_AVG: begin
				if (end4) phase_n = PH_ALIGN;
			end
			PH_ALIGN: begin
				if (end2) begin
					if (half != BLOCK_ALIGN) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_ALIGN, 1'b1};
					end else begin
						phase_n = PH_BITS;
					end
				end
			end
			PH_BITS: begin
				if (end2) begin
					if (half != SAMPLE_BITS) begin
						phase_n = PH_IDLE;
						res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_BITS, 1'b1};
					end else begin
						phase_n = PH_TAG;
					end
				end
			end
			PH_TAG: begin
				// The low byte register doubles as the "this chunk is data" flag here.
				if (end4) begin
					low_n   = (asm_n == TAG_DATA) ? 8'd1 : 8'd0;
					phase_n = PH_SIZE;
				end
			end
			PH_SIZE: begin
				if (end4) begin
					if (low_q != 8'd0) begin
						low_n = 8'd0;
						rem_n = {1'b0, asm_n[31:1]};
						res   = '{1'b1, KIND_HEADER, 16'd0, asm_n[31:1], 4'd0, 1'b0};
						phase_n = (asm_n[31:1] != '0) ? PH_SAMP : PH_IDLE;
					end else begin
						rem_n   = asm_n;
						phase_n = (asm_n != 32'd0) ? PH_SKIP : PH_TAG;
					end
				end
			end
			PH_SKIP: begin
				rem_n = rem_dec;
				if (rem_dec == 32'd0) phase_n = PH_TAG;
			end
			PH_SAMP: begin
				if (!idx_q[0]) begin
					low_n = in_byte;
					idx_n = 2'd1;
				end else begin
					idx_n = 2'd0;
					rem_n = rem_dec;
					res = '{1'b1, KIND_SAMPLE, {in_byte, low_q}, '0, 4'd0,
						rem_dec == 32'd0};
					if (rem_dec == 32'd0) phase_n = PH_IDLE;
				end
			end
			default: begin
			end
		endcase

		// End of file overrides any result unless the file was already finished.
		if (end_of_file) begin
			if (phase_n != PH_IDLE) begin
				res = '{1'b1, KIND_ERROR, 16'd0, '0, ERR_TRUNCATED, 1'b1};
			end
			phase_n = PH_RIFF;
			idx_n   = '0;
			asm_n   = '0;
			rem_n   = '0;
			low_n   = '0;
		end
	end

endmodule

@@ hdl/wavp_checker.sv @@
// Port-level checks of the WAV parser, bound to its top level.
`timescale 1ns / 1ps

module wavp_checker import wavp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_stall,
	input logic [1:0]         kind,
	input logic [15:0]        sample,
	input logic [COUNT_W-1:0] sample_count,
	input logic [3:0]         error_code,
	input logic               last
);

	// A stalled result item stays put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind) &&
		$stable(sample) && $stable(sample_count) && $stable(error_code) && $stable(last))
		else $error("stalled result item changed");

	// Every error ends the file's results.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_ERROR |-> last && error_code <= ERR_TRUNCATED)
		else $error("error item without last or with unknown code");

	// A header item is never the last one and carries no error or sample.
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_HEADER |-> !last && sample == 16'd0 &&
		error_code == 4'd0)
		else $error("malformed header item");

	// Sample items carry no count and no error code.
	a_smp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_SAMPLE |-> sample_count == '0 && error_code == 4'd0)
		else $error("malformed sample item");

endmodule

bind wav_header_pcm_parser wavp_checker u_wavp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.kind        (kind),
	.sample      (sample),
	.sample_count(sample_count),
	.error_code  (error_code),
	.last        (last)
);
